FILE: rtl/sitda_pkg.sv
`default_nettype none

package sitda_pkg;

  // width of the signed value that is converted (8 to 64)
  localparam int unsigned VALUE_WIDTH = 64;

  // decimal digits needed for the largest magnitude, 2^(VALUE_WIDTH-1)
  localparam int unsigned NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int unsigned BCD_WIDTH  = NUM_DIGITS * 4;

  localparam int unsigned BIT_CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam int unsigned DIG_CNT_W = $clog2(NUM_DIGITS + 1);

  localparam int unsigned CHAR_WIDTH = 7;

  localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 7'd48;
  localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 7'd45;

  // shift-and-add-3 correction
  localparam logic [3:0] DABBLE_LIMIT = 4'd5;
  localparam logic [3:0] DABBLE_ADD   = 4'd3;

  typedef struct packed {
    logic load;
    logic shift_bit;
    logic emit_sign;
    logic emit_digit;
    logic drop_digit;
    logic last;
  } sitda_cmd_t;

  typedef struct packed {
    logic neg;
    logic top_zero;
  } sitda_sts_t;

endpackage

`default_nettype wire

FILE: rtl/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text. Each value transfer on the input
// channel yields its decimal text on the output channel, one character per
// transfer, most significant first: '-' for a negative value, then the digits
// with no leading zeros ("0" for zero); last_o marks the final character.
// Only the low VALUE_WIDTH bits of value_i are used (two's complement).
// Operation: one value is in work at a time. After the input transfer, the
// magnitude goes through a shift-and-add-3 binary to BCD converter, one bit
// per cycle; then a '-' is emitted for a negative value, leading zero digits
// are dropped and the remaining digits are emitted. Dropped and emitted digits
// always add up to NUM_DIGITS. The sign and digit steps wait while the output
// register still holds a character that the consumer has not taken.
// The last character sits in the output register while the next value is taken.
`default_nettype none

module signed_int_to_decimal_ascii (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // value channel
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire logic signed [63:0]             value_i,
  // character channel
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic [sitda_pkg::CHAR_WIDTH-1:0]    character_o,
  output logic                                last_o
);
  import sitda_pkg::*;

  // command and status between sequencer and datapath
  sitda_cmd_t cmd;
  sitda_sts_t sts;

  // sequencer: conversion bit count, digit count, output valid
  sitda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: magnitude, BCD shift register, character output register
  sitda_dpath u_dpath (
    .clk_i       (clk_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

FILE: rtl/sitda_dpath.sv
`default_nettype none

module sitda_dpath (
  input  wire                                 clk_i,
  input  wire logic [63:0]                    value_i,
  input  wire sitda_pkg::sitda_cmd_t          cmd_i,
  output sitda_pkg::sitda_sts_t               sts_o,
  output logic [sitda_pkg::CHAR_WIDTH-1:0]    character_o,
  output logic                                last_o
);
  import sitda_pkg::*;

  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] raw_neg;
  logic [VALUE_WIDTH-1:0] mag_q;
  logic [BCD_WIDTH-1:0]   bcd_q;
  logic [BCD_WIDTH-1:0]   bcd_adj;
  logic [3:0]             top_digit;
  logic                   neg_q;
  logic [CHAR_WIDTH-1:0]  char_q;
  logic                   last_q;

  assign raw       = value_i[VALUE_WIDTH-1:0];
  assign raw_neg   = {VALUE_WIDTH{1'b0}} - raw;
  assign top_digit = bcd_q[BCD_WIDTH-1 -: 4];

  // add 3 to every digit of 5 or more before the next shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= DABBLE_LIMIT) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + DABBLE_ADD;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q <= raw[VALUE_WIDTH-1];
      mag_q <= raw[VALUE_WIDTH-1] ? raw_neg : raw;
      bcd_q <= '0;
    end else if (cmd_i.shift_bit) begin
      bcd_q <= {bcd_adj[BCD_WIDTH-2:0], mag_q[VALUE_WIDTH-1]};
      mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
    end else if (cmd_i.emit_sign) begin
      char_q <= ASCII_MINUS;
      last_q <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      char_q <= ASCII_ZERO + {3'b000, top_digit};
      last_q <= cmd_i.last;
      bcd_q  <= {bcd_q[BCD_WIDTH-5:0], 4'b0000};
    end else if (cmd_i.drop_digit) begin
      bcd_q  <= {bcd_q[BCD_WIDTH-5:0], 4'b0000};
    end
  end

  assign sts_o.neg      = neg_q;
  assign sts_o.top_zero = (top_digit == 4'd0);
  assign character_o    = char_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire

FILE: rtl/sitda_ctrl.sv
`default_nettype none

module sitda_ctrl (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  input  wire sitda_pkg::sitda_sts_t  sts_i,
  output sitda_pkg::sitda_cmd_t       cmd_o
);
  import sitda_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SIGN,
    S_SKIP,
    S_EMIT
  } state_e;

  state_e                 state_q, state_d;
  logic [BIT_CNT_W-1:0]   bit_cnt_q, bit_cnt_d;
  logic [DIG_CNT_W-1:0]   dig_cnt_q, dig_cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic                   slot_free;
  logic                   last_digit;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign last_digit = (dig_cnt_q == DIG_CNT_W'(1));

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    bit_cnt_d   = bit_cnt_q;
    dig_cnt_d   = dig_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          bit_cnt_d  = BIT_CNT_W'(VALUE_WIDTH - 1);
          dig_cnt_d  = DIG_CNT_W'(NUM_DIGITS);
          state_d    = S_CONV;
        end
      end
      S_CONV: begin
        cmd_o.shift_bit = 1'b1;
        if (bit_cnt_q == '0) begin
          state_d = S_SIGN;
        end else begin
          bit_cnt_d = bit_cnt_q - BIT_CNT_W'(1);
        end
      end
      S_SIGN: begin
        if (!sts_i.neg) begin
          state_d = S_SKIP;
        end else if (slot_free) begin
          cmd_o.emit_sign = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = S_SKIP;
        end
      end
      S_SKIP: begin
        if (sts_i.top_zero && !last_digit) begin
          cmd_o.drop_digit = 1'b1;
          dig_cnt_d        = dig_cnt_q - DIG_CNT_W'(1);
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd_o.emit_digit = 1'b1;
          cmd_o.last       = last_digit;
          out_valid_d      = 1'b1;
          dig_cnt_d        = dig_cnt_q - DIG_CNT_W'(1);
          if (last_digit) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      dig_cnt_q   <= dig_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // a new character only goes into a free output slot
  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_sign || cmd_o.emit_digit) |-> (!out_valid_q || out_ready_i))
    else $error("character emitted over a pending one");

  // an accepted value starts the conversion
  a_accept_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_CONV))
    else $error("accepted value did not start conversion");

  // the digit count never runs out while a value is in work
  a_dig_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SKIP || state_q == S_EMIT) |-> (dig_cnt_q != '0))
    else $error("digit count exhausted");

  // the final character ends the item
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_digit && cmd_o.last) |=> (state_q == S_IDLE && out_valid_q))
    else $error("last character did not end the item");

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sitda_pkg::*;

  localparam int unsigned DEC_BASE = 10;

  // one character of decimal text as it should leave the block
  typedef struct packed {
    logic [CHAR_WIDTH-1:0] code;
    logic                  last;
  } text_char_t;

  // expands each accepted value into its decimal text and checks the
  // character stream against it, oldest character first
  class decimal_text_ledger;
    text_char_t  due_chars[$];
    int unsigned mismatches = 0;

    function int unsigned pending();
      return due_chars.size();
    endfunction

    function void report(string msg);
      mismatches++;
      $display("%0t: %s", $time, msg);
    endfunction

    // work out the text of one accepted value
    function void note_value(logic [63:0] value);
      logic [63:0] mask;
      logic [63:0] raw;
      logic [63:0] mag;
      logic        neg;
      int unsigned digs[$];
      text_char_t  ch;
      mask = (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);
      raw  = value & mask;
      neg  = raw[VALUE_WIDTH-1];
      // magnitude of the most negative value still fits unsigned
      mag  = neg ? ((64'd0 - raw) & mask) : raw;
      // least significant digit first, one digit even for zero
      do begin
        digs.push_front(int'(mag % DEC_BASE));
        mag = mag / DEC_BASE;
      end while (mag != 0);
      if (neg) begin
        ch.code = ASCII_MINUS;
        ch.last = 1'b0;
        due_chars.push_back(ch);
      end
      foreach (digs[k]) begin
        ch.code = ASCII_ZERO + CHAR_WIDTH'(digs[k]);
        ch.last = (k == digs.size() - 1);
        due_chars.push_back(ch);
      end
    endfunction

    function void check_char(logic [CHAR_WIDTH-1:0] code, logic last);
      text_char_t want;
      if (due_chars.size() == 0) begin
        report($sformatf("character %0d last %0b with nothing expected", code, last));
        return;
      end
      want = due_chars.pop_front();
      if (code !== want.code)
        report($sformatf("character: expected %0d, actual %0d", want.code, code));
      if (last !== want.last)
        report($sformatf("last: expected %0b, actual %0b", want.last, last));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic signed [63:0]    value_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [CHAR_WIDTH-1:0] character_o;
  logic                  last_o;

  decimal_text_ledger ledger = new();

  // random idling on both sides when set; changed only at a rising edge
  bit          idle_en;
  // cycles the receiver still holds off; set at a rising edge, counted down at falling
  int unsigned hold_cnt;

  logic [63:0] corner_vals[$];

  signed_int_to_decimal_ascii u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // random value with most of the weight on interesting magnitudes
  function automatic logic [63:0] rand_value();
    logic [63:0]  v;
    logic [63:0]  p;
    int unsigned  nbits;
    int unsigned  kind;
    v    = {$urandom, $urandom};
    kind = $urandom_range(0, 9);
    case (kind)
      3, 4, 5: begin
        // random bit length, random sign
        nbits = $urandom_range(1, 64);
        v = v >> (64 - nbits);
        if ($urandom_range(0, 1)) v = 64'd0 - v;
      end
      6, 7: begin
        // around a power of ten, where the digit count changes
        p = 64'd1;
        repeat ($urandom_range(0, 18)) p = p * DEC_BASE;
        v = p + 64'($urandom_range(0, 2)) - 64'd1;
        if ($urandom_range(0, 1)) v = 64'd0 - v;
      end
      8: begin
        // close to either end of the range
        if ($urandom_range(0, 1)) v = 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 3));
        else                      v = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
      end
      9: begin
        // tiny values, short texts
        v = 64'($urandom_range(0, 20));
        if ($urandom_range(0, 1)) v = 64'd0 - v;
      end
      default: ; // full range
    endcase
    return v;
  endfunction

  // offer one value, entered and left at a rising edge
  task automatic send_value(input logic [63:0] v);
    @(negedge clk_i);
    while (idle_en && $urandom_range(0, 99) < 29) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    ledger.note_value(v);
  endtask

  // drop valid, then hold the sender until every character has come
  task automatic finish_phase();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
  endtask

  // receiver ready: long hold-off first, then random stalls when enabled
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cnt > 0) begin
        out_ready_i <= 1'b0;
        hold_cnt--;
      end else if (idle_en && $urandom_range(0, 99) < 29) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // every character transfer is checked against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) ledger.check_char(character_o, last_o);
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    value_i    = '0;
    idle_en    = 1'b1;
    hold_cnt   = 0;
    corner_vals = '{
      64'd0, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd9, 64'd0 - 64'd9,
      64'd10, 64'd0 - 64'd10, 64'd99, 64'd100, 64'd123456789,
      64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
      64'h7FFF_FFFF_FFFF_FFFE, 64'd999999999999999999, 64'd1000000000000000000,
      64'd0 - 64'd1000000000000000000, 64'd0 - 64'd999999999999999999,
      64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'd9999999999999999999
    };

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners: extremes, zero, sign, digit count boundaries
    foreach (corner_vals[i]) send_value(corner_vals[i]);
    finish_phase();

    // receiver holds off for a long stretch while values keep coming
    hold_cnt = 400;
    idle_en  = 1'b0;
    repeat (12) send_value(rand_value());
    finish_phase();

    idle_en = 1'b1;
    repeat (130) send_value(rand_value());
    finish_phase();

    // no idling on either side
    idle_en = 1'b0;
    repeat (60) send_value(rand_value());
    finish_phase();

    idle_en  = 1'b1;
    hold_cnt = 250;
    repeat (110) send_value(rand_value());
    finish_phase();

    // let any stray character show up
    repeat (120) @(posedge clk_i);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
